[rtl/circular_deque_engine_assert.svh]
// Assertion macros shared by the circular deque engine modules.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef CIRCULAR_DEQUE_ENGINE_ASSERT_SVH
`define CIRCULAR_DEQUE_ENGINE_ASSERT_SVH

// same-cycle implication
`define CDE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("circular deque engine assertion failed");

// next-cycle implication
`define CDE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("circular deque engine assertion failed");

`endif

[rtl/cde_pkg.sv]
// Shared types and codes for the circular deque engine.
// No dependencies.
`default_nettype none

package cde_pkg;

	localparam int DEPTH_DEF  = 16;
	localparam int DATA_W_DEF = 32;

	localparam int REQ_W    = 3;
	localparam int VALUE_W  = 32;
	localparam int INDEX_W  = 4;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_GET        = 3'd4;
	localparam logic [REQ_W-1:0] REQ_SET        = 3'd5;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd3;

	typedef struct packed {
		logic [REQ_W-1:0]   req_type;
		logic [VALUE_W-1:0] value;
		logic [INDEX_W-1:0] index;
	} cde_req_t;

	typedef struct packed {
		logic [VALUE_W-1:0]  data_out;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
	} cde_rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOKUP,
		S_COMMIT
	} cde_state_t;

	typedef struct packed {
		logic capture;
		logic lookup;
		logic commit;
	} cde_cmd_t;

endpackage

`default_nettype wire

[rtl/circular_deque_engine.sv]
// Top level of the circular deque engine: controller plus datapath.
// Depends on cde_pkg, cde_ctrl and cde_dpath.
//
//   channel   signals              handshake
//   request   start, busy, req     taken at a rising edge with start high, busy low
//   result    done, rsp            one-cycle strobe, taken at the edge ending it
//
// Each request passes through capture, a ring store read, then commit with the
// result on rsp while done is high; busy is low again in the cycle after the result.
// A new request is not accepted until the previous one has committed: busy stays
// high through the registered read of the ring store and its write-back.
// Reset clears the front pointer and the count; the ring store is not cleared.
// The receiver cannot stall; results are never held.
`default_nettype none

module circular_deque_engine #(
	parameter int DEPTH  = cde_pkg::DEPTH_DEF,
	parameter int DATA_W = cde_pkg::DATA_W_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire cde_pkg::cde_req_t req,
	output logic                   done,
	output cde_pkg::cde_rsp_t      rsp
);
	import cde_pkg::*;

	cde_cmd_t cmd;

	cde_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	cde_dpath #(
		.DEPTH  (DEPTH),
		.DATA_W (DATA_W)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

[rtl/cde_ctrl.sv]
// Controller state machine for the circular deque engine.
// Depends on cde_pkg and circular_deque_engine_assert.svh.
`default_nettype none

`include "circular_deque_engine_assert.svh"

module cde_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output logic              busy,
	output logic              done,
	output cde_pkg::cde_cmd_t cmd
);
	import cde_pkg::*;

	cde_state_t state_q;
	cde_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt   = state_q;
		cmd.capture = 1'b0;
		cmd.lookup  = 1'b0;
		cmd.commit  = 1'b0;
		busy        = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_nxt   = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_nxt  = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_nxt  = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	assign done = cmd.commit;

	`CDE_ASSERT_NEXT(a_accept_to_lookup, start && !busy, cmd.lookup)
	`CDE_ASSERT_NEXT(a_lookup_to_commit, cmd.lookup, done)
	`CDE_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0({cmd.capture, cmd.lookup, cmd.commit}))

endmodule

`default_nettype wire

[rtl/cde_dpath.sv]
// Datapath of the circular deque engine: ring store, pointers and result.
// Depends on cde_pkg and circular_deque_engine_assert.svh.
`default_nettype none

`include "circular_deque_engine_assert.svh"

module cde_dpath #(
	parameter int DEPTH  = cde_pkg::DEPTH_DEF,
	parameter int DATA_W = cde_pkg::DATA_W_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cde_pkg::cde_cmd_t cmd,
	input  wire cde_pkg::cde_req_t req,
	output cde_pkg::cde_rsp_t      rsp
);
	import cde_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

	typedef struct packed {
		logic rd;
		logic wr;
		logic cnt_up;
		logic cnt_dn;
		logic front_dn;
		logic front_up;
	} flags_t;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	cde_req_t            req_s1;
	logic [PTR_W-1:0]    front_q;
	logic [CNT_W-1:0]    count_q;
	logic [PTR_W-1:0]    slot_s2;
	logic [STATUS_W-1:0] status_s2;
	flags_t              fl_s2;

	logic [CMP_W-1:0]    idx_w;
	logic [CMP_W-1:0]    cnt_w;
	logic                full;
	logic                empty;
	logic                range_bad;
	logic [PTR_W-1:0]    logical;
	logic [PTR_W:0]      slot_sum;
	logic [PTR_W-1:0]    slot_nxt;
	logic [STATUS_W-1:0] status_nxt;
	flags_t              fl_nxt;
	logic [CNT_W-1:0]    count_nxt;
	logic [PTR_W-1:0]    front_inc;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_s1 <= req;
		end
		if (cmd.lookup) begin
			slot_s2   <= slot_nxt;
			status_s2 <= status_nxt;
		end
	end

	always_comb begin
		idx_w      = CMP_W'(req_s1.index);
		cnt_w      = CMP_W'(count_q);
		full       = (count_q == CNT_W'(DEPTH));
		empty      = (count_q == '0);
		range_bad  = (idx_w >= cnt_w);
		logical    = '0;
		status_nxt = STAT_OK;
		fl_nxt     = '0;
		unique case (req_s1.req_type)
			REQ_PUSH_FRONT: begin
				if (full) begin
					status_nxt = STAT_FULL;
				end else begin
					fl_nxt.wr       = 1'b1;
					fl_nxt.cnt_up   = 1'b1;
					fl_nxt.front_dn = 1'b1;
				end
			end
			REQ_PUSH_BACK: begin
				logical = PTR_W'(count_q);
				if (full) begin
					status_nxt = STAT_FULL;
				end else begin
					fl_nxt.wr     = 1'b1;
					fl_nxt.cnt_up = 1'b1;
				end
			end
			REQ_POP_FRONT: begin
				if (empty) begin
					status_nxt = STAT_EMPTY;
				end else begin
					fl_nxt.rd       = 1'b1;
					fl_nxt.cnt_dn   = 1'b1;
					fl_nxt.front_up = 1'b1;
				end
			end
			REQ_POP_BACK: begin
				logical = PTR_W'(count_q - CNT_W'(1));
				if (empty) begin
					status_nxt = STAT_EMPTY;
				end else begin
					fl_nxt.rd     = 1'b1;
					fl_nxt.cnt_dn = 1'b1;
				end
			end
			REQ_GET: begin
				logical = PTR_W'(req_s1.index);
				if (range_bad) begin
					status_nxt = STAT_RANGE;
				end else begin
					fl_nxt.rd = 1'b1;
				end
			end
			REQ_SET: begin
				logical = PTR_W'(req_s1.index);
				if (range_bad) begin
					status_nxt = STAT_RANGE;
				end else begin
					fl_nxt.rd = 1'b1;
					fl_nxt.wr = 1'b1;
				end
			end
			default: begin
			end
		endcase

		slot_sum = {1'b0, front_q} + {1'b0, logical};
		if (fl_nxt.front_dn) begin
			slot_nxt = (front_q == '0) ? PTR_W'(DEPTH - 1) : front_q - PTR_W'(1);
		end else if (slot_sum >= (PTR_W + 1)'(DEPTH)) begin
			slot_nxt = PTR_W'(slot_sum - (PTR_W + 1)'(DEPTH));
		end else begin
			slot_nxt = PTR_W'(slot_sum);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			rd_data_q <= mem[slot_nxt];
		end
		if (cmd.commit && fl_s2.wr) begin
			mem[slot_s2] <= DATA_W'(req_s1.value);
		end
	end

	always_comb begin
		if (fl_s2.cnt_up) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (fl_s2.cnt_dn) begin
			count_nxt = count_q - CNT_W'(1);
		end else begin
			count_nxt = count_q;
		end
		front_inc = (slot_s2 == PTR_W'(DEPTH - 1)) ? '0 : slot_s2 + PTR_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			fl_s2   <= '0;
		end else begin
			if (cmd.lookup) begin
				fl_s2 <= fl_nxt;
			end
			if (cmd.commit) begin
				count_q <= count_nxt;
				if (fl_s2.front_dn) begin
					front_q <= slot_s2;
				end else if (fl_s2.front_up) begin
					front_q <= front_inc;
				end
			end
		end
	end

	assign rsp.data_out = fl_s2.rd ? VALUE_W'(rd_data_q) : '0;
	assign rsp.status   = status_s2;
	assign rsp.count    = COUNT_W'(count_nxt);

	`CDE_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH))
	`CDE_ASSERT_NOW(a_write_ok, cmd.commit && fl_s2.wr, status_s2 == STAT_OK)
	`CDE_ASSERT_NOW(a_no_overfill, cmd.commit && fl_s2.cnt_up, count_q != CNT_W'(DEPTH))

endmodule

`default_nettype wire

[tb/tb_circular_deque_engine.sv]
// Self-checking testbench for circular_deque_engine: directed and random request traffic,
// each result checked against an in-bench deque predictor held in a scoreboard class.
// Depends on cde_pkg and the circular_deque_engine RTL.
`default_nettype none

module tb_circular_deque_engine;
	timeunit 1ns;
	timeprecision 1ps;

	import cde_pkg::*;

	localparam int RING_DEPTH = DEPTH_DEF;
	localparam int RANDOM_ITEMS = 550;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [REQ_W-1:0] REQ_NOP_SIX = 3'd6;
	localparam logic [REQ_W-1:0] REQ_NOP_SEVEN = 3'd7;

	class deque_scoreboard;
		logic [VALUE_W-1:0] ring [RING_DEPTH];
		logic [INDEX_W-1:0] front;
		logic [COUNT_W-1:0] held;
		cde_rsp_t owed_rsp [$];
		int errors;

		function new();
			front = '0;
			held = '0;
			errors = 0;
		endfunction

		function int pending();
			return owed_rsp.size();
		endfunction

		function void note_request(cde_req_t r);
			cde_rsp_t rsp_exp;
			logic [INDEX_W-1:0] slot;
			rsp_exp.data_out = '0;
			rsp_exp.status = STAT_OK;
			case (r.req_type)
				REQ_PUSH_FRONT: begin
					if (held == RING_DEPTH) begin
						rsp_exp.status = STAT_FULL;
					end else begin
						front = front - 1'b1;
						ring[front] = r.value;
						held = held + 1'b1;
					end
				end
				REQ_PUSH_BACK: begin
					if (held == RING_DEPTH) begin
						rsp_exp.status = STAT_FULL;
					end else begin
						slot = front + held[INDEX_W-1:0];
						ring[slot] = r.value;
						held = held + 1'b1;
					end
				end
				REQ_POP_FRONT: begin
					if (held == 0) begin
						rsp_exp.status = STAT_EMPTY;
					end else begin
						rsp_exp.data_out = ring[front];
						front = front + 1'b1;
						held = held - 1'b1;
					end
				end
				REQ_POP_BACK: begin
					if (held == 0) begin
						rsp_exp.status = STAT_EMPTY;
					end else begin
						slot = front + held[INDEX_W-1:0] - 1'b1;
						rsp_exp.data_out = ring[slot];
						held = held - 1'b1;
					end
				end
				REQ_GET: begin
					if ({1'b0, r.index} >= held) begin
						rsp_exp.status = STAT_RANGE;
					end else begin
						slot = front + r.index;
						rsp_exp.data_out = ring[slot];
					end
				end
				REQ_SET: begin
					if ({1'b0, r.index} >= held) begin
						rsp_exp.status = STAT_RANGE;
					end else begin
						slot = front + r.index;
						rsp_exp.data_out = ring[slot];
						ring[slot] = r.value;
					end
				end
				default: begin
				end
			endcase
			rsp_exp.count = held;
			owed_rsp.push_back(rsp_exp);
		endfunction

		function void check_result(cde_rsp_t got);
			cde_rsp_t want;
			if (owed_rsp.size() == 0) begin
				$display("%0t: unexpected transaction: data_out %h status %0d count %0d",
					$time, got.data_out, got.status, got.count);
				errors++;
				return;
			end
			want = owed_rsp.pop_front();
			if (got.data_out !== want.data_out) begin
				$display("%0t: data_out expected %h actual %h", $time, want.data_out, got.data_out);
				errors++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				errors++;
			end
			if (got.count !== want.count) begin
				$display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	cde_req_t req;
	cde_rsp_t rsp;
	int cycles = 0;
	deque_scoreboard sb;

	circular_deque_engine uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	always #4ns clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(rsp);
			if (start && !busy)
				sb.note_request(req);
		end
	end

	function automatic cde_req_t req_of(logic [REQ_W-1:0] op, logic [VALUE_W-1:0] val,
			logic [INDEX_W-1:0] idx);
		cde_req_t r;
		r.req_type = op;
		r.value = val;
		r.index = idx;
		return r;
	endfunction

	function automatic cde_req_t random_request(int held_hint, int mode);
		cde_req_t r;
		int roll;
		int push_pct;
		int pop_pct;
		roll = $urandom_range(0, 99);
		push_pct = (mode == 0) ? 55 : (mode == 1) ? 15 : 30;
		pop_pct = (mode == 0) ? 15 : (mode == 1) ? 55 : 30;
		if (roll < push_pct)
			r.req_type = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
		else if (roll < push_pct + pop_pct)
			r.req_type = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
		else if (roll < 98)
			r.req_type = $urandom_range(0, 1) ? REQ_SET : REQ_GET;
		else
			r.req_type = $urandom_range(0, 1) ? REQ_NOP_SEVEN : REQ_NOP_SIX;
		roll = $urandom_range(0, 9);
		r.value = (roll == 0) ? '0 : (roll == 1) ? '1 : VALUE_W'($urandom);
		if (held_hint > 0 && $urandom_range(0, 99) < 80)
			r.index = INDEX_W'($urandom_range(0, held_hint - 1));
		else
			r.index = INDEX_W'($urandom_range(0, 15));
		return r;
	endfunction

	task automatic send_request(cde_req_t item, bit may_idle);
		int gap;
		gap = 0;
		if (may_idle && $urandom_range(0, 99) < 31)
			gap = $urandom_range(1, 6);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= item;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	initial begin
		cde_req_t item;
		int sent;
		bit paused;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(req_of(REQ_POP_FRONT, '1, '0), 1'b1);
		send_request(req_of(REQ_POP_BACK, '0, '1), 1'b1);
		send_request(req_of(REQ_GET, '0, '0), 1'b1);
		send_request(req_of(REQ_SET, '1, '1), 1'b1);
		send_request(req_of(REQ_NOP_SIX, '1, '1), 1'b1);
		send_request(req_of(REQ_NOP_SEVEN, '0, '0), 1'b1);
		for (int i = 0; i < RING_DEPTH; i++) begin
			item = req_of(i[0] ? REQ_PUSH_BACK : REQ_PUSH_FRONT,
				(i == 0) ? '1 : (i == 1) ? '0 : VALUE_W'($urandom), '0);
			send_request(item, 1'b1);
		end
		send_request(req_of(REQ_PUSH_BACK, '1, '0), 1'b1);
		send_request(req_of(REQ_PUSH_FRONT, '0, '0), 1'b1);
		send_request(req_of(REQ_GET, '0, '1), 1'b1);
		send_request(req_of(REQ_SET, 32'h5A5A_A5A5, '0), 1'b1);
		wait_drained();

		sent = 0;
		paused = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			if (sent == 150 && !paused) begin
				wait_drained();
				paused = 1'b1;
			end
			item = random_request(sb.held, (sent / 40) % 3);
			send_request(item, !(sent >= 250 && sent < 350));
			if (item.req_type != REQ_NOP_SIX && item.req_type != REQ_NOP_SEVEN)
				sent++;
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

`default_nettype wire
